/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect signals named clock and
// reset in the enclosing module and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define FSH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression that must never be true.
`define FSH_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

/* rtl/fsh_pkg.sv */
`default_nettype none

package fsh_pkg;

   // profile phases; codes above COMPLETE act as complete
   localparam logic [2:0] PH_HEATING  = 3'd0;
   localparam logic [2:0] PH_HOLDING  = 3'd1;
   localparam logic [2:0] PH_COOLING  = 3'd2;
   localparam logic [2:0] PH_COOLDOWN = 3'd3;
   localparam logic [2:0] PH_COMPLETE = 3'd4;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_STALL = 2'd1;
   localparam logic [1:0] FAULT_HOLD  = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_STALL_WINDOW = 3'd0;
   localparam logic [2:0] REG_STALL_RATE   = 3'd1;
   localparam logic [2:0] REG_STALL_LAG    = 3'd2;
   localparam logic [2:0] REG_HOLD_BAND    = 3'd3;
   localparam logic [2:0] REG_HOLD_LIMIT   = 3'd4;

   localparam int ADDR_W = 5;

   localparam logic [31:0] RST_STALL_WINDOW = 32'd60000;
   localparam logic [6:0]  RST_STALL_RATE   = 7'd50;
   localparam logic [14:0] RST_STALL_LAG    = 15'd50;
   localparam logic [14:0] RST_HOLD_BAND    = 15'd100;
   localparam logic [31:0] RST_HOLD_LIMIT   = 32'd300000;

   // expected rise must exceed 1.0 C
   localparam logic signed [16:0] MIN_RISE_TENTHS = 17'sd10;
   localparam logic signed [24:0] PERCENT_SCALE   = 25'sd100;

   typedef struct packed {
      logic [31:0] stall_window_ms;
      logic [6:0]  stall_rate_percent;
      logic [14:0] stall_min_lag_tenths;
      logic [14:0] hold_band_tenths;
      logic [31:0] hold_limit_ms;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/fsh_if.sv */
`default_nettype none

interface fsh_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         phase;
   logic               new_stage;
   logic signed [15:0] setpoint_tenths;
   logic signed [15:0] temperature_tenths;
   logic [15:0]        tick_ms;

   modport source (output valid, phase, new_stage, setpoint_tenths,
                   temperature_tenths, tick_ms, input ready);
   modport sink   (input valid, phase, new_stage, setpoint_tenths,
                   temperature_tenths, tick_ms, output ready);
endinterface

interface fsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  fault_code;
   logic [31:0] fault_time_ms;
   logic        drive_heater;
   logic        clear_heater;
   logic        fan_on;

   modport source (output valid, fault_code, fault_time_ms, drive_heater,
                   clear_heater, fan_on, input ready);
   modport sink   (input valid, fault_code, fault_time_ms, drive_heater,
                   clear_heater, fan_on, output ready);
endinterface

`default_nettype wire

/* rtl/fsh_csr.sv */
`default_nettype none

module fsh_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [fsh_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]               pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output fsh_pkg::cfg_type               cfg
);

   fsh_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[fsh_pkg::ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            fsh_pkg::REG_STALL_WINDOW: cfg_in.stall_window_ms      = pwdata;
            fsh_pkg::REG_STALL_RATE:   cfg_in.stall_rate_percent   = pwdata[6:0];
            fsh_pkg::REG_STALL_LAG:    cfg_in.stall_min_lag_tenths = pwdata[14:0];
            fsh_pkg::REG_HOLD_BAND:    cfg_in.hold_band_tenths     = pwdata[14:0];
            fsh_pkg::REG_HOLD_LIMIT:   cfg_in.hold_limit_ms        = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         fsh_pkg::REG_STALL_WINDOW: prdata = cfg_ff.stall_window_ms;
         fsh_pkg::REG_STALL_RATE:   prdata = {25'd0, cfg_ff.stall_rate_percent};
         fsh_pkg::REG_STALL_LAG:    prdata = {17'd0, cfg_ff.stall_min_lag_tenths};
         fsh_pkg::REG_HOLD_BAND:    prdata = {17'd0, cfg_ff.hold_band_tenths};
         fsh_pkg::REG_HOLD_LIMIT:   prdata = cfg_ff.hold_limit_ms;
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_window_ms      <= fsh_pkg::RST_STALL_WINDOW;
         cfg_ff.stall_rate_percent   <= fsh_pkg::RST_STALL_RATE;
         cfg_ff.stall_min_lag_tenths <= fsh_pkg::RST_STALL_LAG;
         cfg_ff.hold_band_tenths     <= fsh_pkg::RST_HOLD_BAND;
         cfg_ff.hold_limit_ms        <= fsh_pkg::RST_HOLD_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fsh_core.sv */
`default_nettype none

`include "assert_macros.svh"

module fsh_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  fsh_pkg::cfg_type cfg,
   fsh_req_if.sink         req_ch,
   fsh_rsp_if.source       rsp_ch
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [2:0]         in_phase_ff;
   logic               in_chg_ff;
   logic signed [15:0] in_sp_ff;
   logic signed [15:0] in_temp_ff;
   logic [15:0]        in_tick_ff;

   // supervisor state
   logic               trk_ff, trk_in;
   logic signed [15:0] wst_ff, wst_in;
   logic signed [15:0] wss_ff, wss_in;
   logic [31:0]        we_ff, we_in;
   logic [31:0]        hv_ff, hv_in;
   logic               fan_ff, fan_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_code_ff, out_code_in;
   logic [31:0]        out_elapsed_ff, out_elapsed_in;
   logic               out_drive_ff, out_drive_in;
   logic               out_clear_ff, out_clear_in;
   logic               out_fan_ff, out_fan_in;

   logic req_fire, advance;

   logic               heating, holding, cooling, restart, expired, rebase;
   logic [32:0]        we_sum, hv_sum;
   logic [31:0]        we_sat, hv_sat;
   logic signed [16:0] sp_x, temp_x, expected, actual, lag, dev;
   logic [16:0]        dev_abs;
   logic signed [24:0] act_x100, exp_x_rate;
   logic               out_band, stall_fault, hold_fault, drive;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !reset && (!in_valid_ff || advance);
   assign req_fire       = req_ch.valid && req_ch.ready;

   assign heating = (in_phase_ff == fsh_pkg::PH_HEATING);
   assign holding = (in_phase_ff == fsh_pkg::PH_HOLDING);
   assign cooling = (in_phase_ff == fsh_pkg::PH_COOLING) ||
                    (in_phase_ff == fsh_pkg::PH_COOLDOWN);

   // stall window
   assign restart = heating && (!trk_ff || in_chg_ff);
   assign we_sum  = {1'b0, we_ff} + {17'd0, in_tick_ff};
   assign we_sat  = we_sum[32] ? '1 : we_sum[31:0];
   assign expired = heating && !restart && (we_sat >= cfg.stall_window_ms);

   assign sp_x       = 17'(in_sp_ff);
   assign temp_x     = 17'(in_temp_ff);
   assign expected   = sp_x - 17'(wss_ff);
   assign actual     = temp_x - 17'(wst_ff);
   assign lag        = sp_x - temp_x;
   assign act_x100   = 25'(actual) * fsh_pkg::PERCENT_SCALE;
   assign exp_x_rate = 25'(expected) * $signed({18'd0, cfg.stall_rate_percent});

   assign stall_fault = expired
                     && (18'(lag) > $signed({3'd0, cfg.stall_min_lag_tenths}))
                     && (expected > fsh_pkg::MIN_RISE_TENTHS)
                     && (act_x100 < exp_x_rate);
   assign rebase = expired && !stall_fault;

   // hold band
   assign dev      = temp_x - sp_x;
   assign dev_abs  = dev[16] ? 17'(-dev) : 17'(dev);
   assign out_band = dev_abs > {2'd0, cfg.hold_band_tenths};
   assign hv_sum   = {1'b0, hv_ff} + {17'd0, in_tick_ff};
   assign hv_sat   = hv_sum[32] ? '1 : hv_sum[31:0];
   assign hold_fault = !stall_fault && holding && out_band && (hv_sat >= cfg.hold_limit_ms);

   assign drive = !stall_fault && !hold_fault && !cooling;

   always_comb begin
      trk_in = heating && !stall_fault;
      wst_in = wst_ff;
      wss_in = wss_ff;
      we_in  = we_ff;
      if (restart || rebase) begin
         wst_in = in_temp_ff;
         wss_in = in_sp_ff;
         we_in  = 32'd0;
      end else if (heating) begin
         we_in = we_sat;
      end

      // a stall fault skips the hold logic entirely
      if (stall_fault)
         hv_in = hv_ff;
      else if (holding && out_band && !hold_fault)
         hv_in = hv_sat;
      else
         hv_in = 32'd0;

      fan_in = fan_ff || (in_chg_ff && cooling);

      if (stall_fault) begin
         out_code_in    = fsh_pkg::FAULT_STALL;
         out_elapsed_in = we_sat;
      end else if (hold_fault) begin
         out_code_in    = fsh_pkg::FAULT_HOLD;
         out_elapsed_in = hv_sat;
      end else begin
         out_code_in    = fsh_pkg::FAULT_NONE;
         out_elapsed_in = 32'd0;
      end
      out_drive_in = drive;
      out_clear_in = drive && in_chg_ff;
      out_fan_in   = fan_in;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = 1'b1;
      else if (rsp_ch.ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         trk_ff       <= 1'b0;
         wst_ff       <= '0;
         wss_ff       <= '0;
         we_ff        <= '0;
         hv_ff        <= '0;
         fan_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            trk_ff <= trk_in;
            wst_ff <= wst_in;
            wss_ff <= wss_in;
            we_ff  <= we_in;
            hv_ff  <= hv_in;
            fan_ff <= fan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_phase_ff <= req_ch.phase;
         in_chg_ff   <= req_ch.new_stage;
         in_sp_ff    <= req_ch.setpoint_tenths;
         in_temp_ff  <= req_ch.temperature_tenths;
         in_tick_ff  <= req_ch.tick_ms;
      end
      if (advance) begin
         out_code_ff    <= out_code_in;
         out_elapsed_ff <= out_elapsed_in;
         out_drive_ff   <= out_drive_in;
         out_clear_ff   <= out_clear_in;
         out_fan_ff     <= out_fan_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.fault_code    = out_code_ff;
   assign rsp_ch.fault_time_ms = out_elapsed_ff;
   assign rsp_ch.drive_heater  = out_drive_ff;
   assign rsp_ch.clear_heater  = out_clear_ff;
   assign rsp_ch.fan_on        = out_fan_ff;

   `FSH_ASSERT_NEVER(a_fault_with_drive, out_valid_ff && (out_code_ff != fsh_pkg::FAULT_NONE) && (out_drive_ff || out_clear_ff), "fault transaction still drives heater")
   `FSH_ASSERT(a_fan_sticky, fan_ff |=> fan_ff, "fan request dropped")
   `FSH_ASSERT(a_stall_ends_window, advance && stall_fault |=> !trk_ff, "stall window kept after fault")
   `FSH_ASSERT(a_restart_zeroes_window, advance && restart |=> (we_ff == 32'd0) && trk_ff, "window not restarted")

endmodule

`default_nettype wire

/* rtl/furnace_stall_hold_fault_supervisor_unit.sv */
// Furnace stall and hold-drift supervisor. Each transaction on req_ch is one
// control tick (phase, stage change, setpoint, temperature, elapsed ms) and
// produces exactly one transaction on rsp_ch with the fault code, the window
// or violation time at the fault, heater drive/clear and the sticky fan
// request. A tick is captured in an input register and evaluated in one
// registered step into the result register. With rsp_ch ready, one tick per
// clock is sustained; the tick is evaluated from the input register into the
// result register once that register is empty or its result is being taken. While a
// result waits, one more tick can be captured in the input register, after
// which req_ch.ready stays low until the result is taken. The APB registers
// (stall window, stall rate, minimum lag, hold band, hold limit at byte
// addresses 0, 4, 8, 12, 16) take their defaults at reset and should be
// written only while no tick is in flight.
`default_nettype none

module furnace_stall_hold_fault_supervisor_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   fsh_req_if.sink                        req_ch,
   fsh_rsp_if.source                      rsp_ch,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [fsh_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]               pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   fsh_pkg::cfg_type cfg;

   fsh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fsh_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

/* tb/tb_furnace_stall_hold_fault_supervisor_unit.sv */
`timescale 1ns / 1ps

module tb_furnace_stall_hold_fault_supervisor_unit;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [2:0]         phase;
      logic               new_stage;
      logic signed [15:0] setpoint_tenths;
      logic signed [15:0] temperature_tenths;
      logic [15:0]        tick_ms;
   } tick_type;

   typedef struct packed {
      logic [1:0]  fault_code;
      logic [31:0] fault_time_ms;
      logic        drive_heater;
      logic        clear_heater;
      logic        fan_on;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [fsh_pkg::ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   fsh_req_if req_bus ();
   fsh_rsp_if rsp_bus ();

   furnace_stall_hold_fault_supervisor_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // supervisor model state
   fsh_pkg::cfg_type   cfg_shadow = '{fsh_pkg::RST_STALL_WINDOW, fsh_pkg::RST_STALL_RATE,
                                      fsh_pkg::RST_STALL_LAG, fsh_pkg::RST_HOLD_BAND,
                                      fsh_pkg::RST_HOLD_LIMIT};
   logic               tracking = 1'b0;
   logic signed [15:0] base_temp = '0;
   logic signed [15:0] base_setpoint = '0;
   logic [31:0]        window_ms = '0;
   logic [31:0]        drift_ms = '0;
   logic               fan_latched = 1'b0;

   tick_type    tick_backlog[$];
   verdict_type predicted_verdicts[$];
   tick_type    driven_tick;
   bit          idle_enable = 1'b1;
   int          cycle_count = 0;
   int          error_count = 0;
   int          ticks_accepted = 0;
   int          stall_faults = 0;
   int          drift_faults = 0;
   int          settings_applied = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic verdict_type supervise(tick_type t);
      verdict_type v;
      logic [2:0] ph;
      logic chilling;
      longint sp, tp, rise_goal, rise_seen, lag, dev;
      v = '0;
      ph = (t.phase > fsh_pkg::PH_COMPLETE) ? fsh_pkg::PH_COMPLETE : t.phase;
      chilling = (ph == fsh_pkg::PH_COOLING) || (ph == fsh_pkg::PH_COOLDOWN);
      sp = longint'(t.setpoint_tenths);
      tp = longint'(t.temperature_tenths);
      if (t.new_stage && chilling) fan_latched = 1'b1;

      if (ph == fsh_pkg::PH_HEATING) begin
         if (!tracking || t.new_stage) begin
            base_temp = t.temperature_tenths;
            base_setpoint = t.setpoint_tenths;
            window_ms = '0;
            tracking = 1'b1;
         end else begin
            window_ms = sat_sum(window_ms, t.tick_ms);
            if (window_ms >= cfg_shadow.stall_window_ms) begin
               rise_goal = sp - longint'(base_setpoint);
               rise_seen = tp - longint'(base_temp);
               lag = sp - tp;
               if (lag > longint'(cfg_shadow.stall_min_lag_tenths) &&
                   rise_goal > longint'(fsh_pkg::MIN_RISE_TENTHS) &&
                   rise_seen * 100 < rise_goal * longint'(cfg_shadow.stall_rate_percent)) begin
                  v.fault_code = fsh_pkg::FAULT_STALL;
                  v.fault_time_ms = window_ms;
                  tracking = 1'b0;
               end else begin
                  base_temp = t.temperature_tenths;
                  base_setpoint = t.setpoint_tenths;
                  window_ms = '0;
               end
            end
         end
      end else begin
         tracking = 1'b0;
      end

      if (v.fault_code == fsh_pkg::FAULT_NONE) begin
         if (ph == fsh_pkg::PH_HOLDING) begin
            dev = tp - sp;
            if (dev < 0) dev = -dev;
            if (dev > longint'(cfg_shadow.hold_band_tenths)) begin
               drift_ms = sat_sum(drift_ms, t.tick_ms);
               if (drift_ms >= cfg_shadow.hold_limit_ms) begin
                  v.fault_code = fsh_pkg::FAULT_HOLD;
                  v.fault_time_ms = drift_ms;
                  drift_ms = '0;
               end
            end else begin
               drift_ms = '0;
            end
         end else begin
            drift_ms = '0;
         end
      end

      v.drive_heater = (v.fault_code == fsh_pkg::FAULT_NONE) && !chilling;
      v.clear_heater = v.drive_heater && t.new_stage;
      v.fan_on = fan_latched;
      return v;
   endfunction

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            predicted_verdicts.push_back(supervise(driven_tick));
            ticks_accepted++;
         end
         if (tick_backlog.size() != 0 && !(idle_enable && $urandom_range(99) < 26)) begin
            driven_tick = tick_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.phase <= driven_tick.phase;
            req_bus.new_stage <= driven_tick.new_stage;
            req_bus.setpoint_tenths <= driven_tick.setpoint_tenths;
            req_bus.temperature_tenths <= driven_tick.temperature_tenths;
            req_bus.tick_ms <= driven_tick.tick_ms;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      verdict_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.fault_code, rsp_bus.fault_time_ms, rsp_bus.drive_heater,
                    rsp_bus.clear_heater, rsp_bus.fan_on};
            if (got.fault_code == fsh_pkg::FAULT_STALL) stall_faults++;
            if (got.fault_code == fsh_pkg::FAULT_HOLD) drift_faults++;
            if (predicted_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: result with nothing pending: fault=%0d elapsed=%0d",
                           got.fault_code, got.fault_time_ms);
            end else begin
               want = predicted_verdicts.pop_front();
               if (got.fault_code != want.fault_code ||
                   got.fault_time_ms != want.fault_time_ms ||
                   got.drive_heater != want.drive_heater ||
                   got.clear_heater != want.clear_heater ||
                   got.fan_on != want.fan_on) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"ERROR at %0t: expected fault=%0d elapsed=%0d drive=%0b ",
                               "clear=%0b fan=%0b, got fault=%0d elapsed=%0d drive=%0b ",
                               "clear=%0b fan=%0b"}, $realtime,
                              want.fault_code, want.fault_time_ms, want.drive_heater,
                              want.clear_heater, want.fan_on, got.fault_code,
                              got.fault_time_ms, got.drive_heater, got.clear_heater,
                              got.fan_on);
               end
            end
         end
         rsp_bus.ready <= !(idle_enable && $urandom_range(99) < 26);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout: %0d ticks accepted, %0d results pending",
                  ticks_accepted, predicted_verdicts.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         fsh_pkg::REG_STALL_WINDOW: cfg_shadow.stall_window_ms = value;
         fsh_pkg::REG_STALL_RATE:   cfg_shadow.stall_rate_percent = value[6:0];
         fsh_pkg::REG_STALL_LAG:    cfg_shadow.stall_min_lag_tenths = value[14:0];
         fsh_pkg::REG_HOLD_BAND:    cfg_shadow.hold_band_tenths = value[14:0];
         fsh_pkg::REG_HOLD_LIMIT:   cfg_shadow.hold_limit_ms = value;
         default: ;
      endcase
   endtask

   // narrow registers optionally get random junk above their width
   task automatic apply_settings(input logic [31:0] window, input logic [6:0] rate,
                                 input logic [14:0] lag, input logic [14:0] band,
                                 input logic [31:0] limit, input bit garble);
      logic [31:0] junk;
      junk = garble ? $urandom : 32'd0;
      csr_write(fsh_pkg::REG_STALL_WINDOW, window);
      csr_write(fsh_pkg::REG_STALL_RATE, {junk[31:7], rate});
      csr_write(fsh_pkg::REG_STALL_LAG, {junk[31:15], lag});
      junk = garble ? $urandom : 32'd0;
      csr_write(fsh_pkg::REG_HOLD_BAND, {junk[31:15], band});
      csr_write(fsh_pkg::REG_HOLD_LIMIT, limit);
      settings_applied++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_bus.valid || predicted_verdicts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_tick(input logic [2:0] ph, input logic chg, input int sp,
                            input int temp, input int ms);
      tick_type t;
      t.phase = ph;
      t.new_stage = chg;
      t.setpoint_tenths = sp[15:0];
      t.temperature_tenths = temp[15:0];
      t.tick_ms = ms[15:0];
      tick_backlog.push_back(t);
   endtask

   function automatic int clamp_tenths(int v);
      return (v < -2000) ? -2000 : (v > 20000) ? 20000 : v;
   endfunction

   function automatic int random_tick_ms();
      int r;
      r = $urandom_range(99);
      if (r < 35) return $urandom_range(0, 400);
      if (r < 80) return $urandom_range(0, 3000);
      if (r < 95) return $urandom_range(0, 65535);
      return r[0] ? 0 : 65535;
   endfunction

   task automatic queue_stage(input logic [2:0] ph, input int len);
      int sp, temp, offset, band;
      bit stalled, drifting;
      sp = $urandom_range(0, 17000) - 2000;
      temp = clamp_tenths(sp - $urandom_range(0, 300));
      stalled = 1'($urandom_range(1));
      drifting = 1'($urandom_range(1));
      band = int'(cfg_shadow.hold_band_tenths);
      for (int i = 0; i < len; i++) begin
         case (ph)
            fsh_pkg::PH_HEATING: begin
               sp = clamp_tenths(sp + $urandom_range(0, 40));
               temp = clamp_tenths(temp + (stalled ? $urandom_range(0, 3) - 1
                                                   : $urandom_range(0, 45)));
            end
            fsh_pkg::PH_HOLDING: begin
               if (drifting || $urandom_range(99) < 10)
                  offset = band + $urandom_range(1, 300);
               else
                  offset = $urandom_range(0, band);
               if ($urandom_range(1)) offset = -offset;
               temp = clamp_tenths(sp + offset);
            end
            default: begin
               sp = clamp_tenths(sp - $urandom_range(0, 30));
               temp = clamp_tenths(temp - $urandom_range(0, 30));
            end
         endcase
         push_tick(ph, (i == 0) || ($urandom_range(99) < 4), sp, temp, random_tick_ms());
      end
   endtask

   task automatic queue_profile(input int n_ticks);
      tick_type t;
      logic [63:0] raw;
      int pick, len;
      logic [2:0] ph;
      while (n_ticks > 0) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            raw = {$urandom, $urandom};
            t = raw[$bits(tick_type)-1:0];
            tick_backlog.push_back(t);
            n_ticks--;
         end else begin
            if (pick < 46) ph = fsh_pkg::PH_HEATING;
            else if (pick < 76) ph = fsh_pkg::PH_HOLDING;
            else if (pick < 84) ph = fsh_pkg::PH_COOLING;
            else if (pick < 91) ph = fsh_pkg::PH_COOLDOWN;
            else ph = 3'($urandom_range(int'(fsh_pkg::PH_COMPLETE), 7));
            len = $urandom_range(2, 24);
            queue_stage(ph, len);
            n_ticks -= len;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.phase = fsh_pkg::PH_HEATING;
      req_bus.new_stage = 1'b0;
      req_bus.setpoint_tenths = '0;
      req_bus.temperature_tenths = '0;
      req_bus.tick_ms = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 60 s window, 50 %, lag 5.0 C, band 10.0 C, 300 s limit
      push_tick(fsh_pkg::PH_HEATING, 1'b1, -2000, -2000, 0);
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 20000, -2000, 65535);   // no rise at all: stall
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 20000, -1990, 100);     // restarts after stall
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 20000, -1900, 0);
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 20000, 20000, 65535);   // at setpoint: new baseline
      push_tick(fsh_pkg::PH_HEATING, 1'b1, 1000, 900, 65535);      // stage change restarts window
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 1200, 1150, 65535);     // lag exactly at minimum
      push_tick(fsh_pkg::PH_HOLDING, 1'b1, 5000, 5100, 1000);      // deviation exactly at band
      repeat (5) push_tick(fsh_pkg::PH_HOLDING, 1'b0, 5000, 4899, 65535);
      push_tick(fsh_pkg::PH_HOLDING, 1'b0, 5000, 5200, 1000);
      push_tick(fsh_pkg::PH_HOLDING, 1'b0, 5000, 5000, 1000);
      push_tick(fsh_pkg::PH_COOLING, 1'b0, 3000, 4000, 500);       // no stage change: fan stays off
      push_tick(fsh_pkg::PH_COOLING, 1'b1, 3000, 4000, 500);
      push_tick(fsh_pkg::PH_COOLDOWN, 1'b1, 0, 2000, 500);
      push_tick(fsh_pkg::PH_COMPLETE, 1'b1, 0, 1000, 500);
      push_tick(fsh_pkg::PH_COMPLETE + 3'd1, 1'b0, 20000, -2000, 65535);
      push_tick(fsh_pkg::PH_COMPLETE + 3'd2, 1'b1, -2000, 20000, 0);
      push_tick(fsh_pkg::PH_COMPLETE + 3'd3, 1'b0, 0, 0, 1);
      push_tick(fsh_pkg::PH_HEATING, 1'b0, 100, 50, 10);
      wait_drained();

      apply_settings(32'd2000, 7'd50, 15'd50, 15'd100, 32'd3000, 1'b0);
      queue_profile(105);
      wait_drained();

      // zero window and zero limit fault or rebaseline on the first tracked tick
      apply_settings(32'd0, 7'd0, 15'd0, 15'd0, 32'd0, 1'b0);
      queue_profile(105);
      wait_drained();

      apply_settings(32'd500, 7'd127, 15'h7FFF, 15'h7FFF, 32'd1, 1'b0);
      queue_profile(105);
      wait_drained();

      idle_enable = 1'b0;
      apply_settings(32'd10000, 7'd100, 15'd20000, 15'd20000, 32'd20000, 1'b0);
      queue_profile(105);
      wait_drained();
      idle_enable = 1'b1;

      repeat (2) begin
         apply_settings($urandom_range(1, 20000), 7'($urandom_range(0, 127)),
                        15'($urandom_range(0, 400)), 15'($urandom_range(0, 400)),
                        $urandom_range(1, 30000), 1'b1);
         queue_profile(105);
         wait_drained();
      end

      apply_settings($urandom_range(1, 5000), 7'($urandom_range(0, 100)),
                     15'($urandom_range(0, 200)), 15'($urandom_range(0, 200)),
                     $urandom_range(1, 8000), 1'b1);
      queue_profile(105);
      wait_drained();

      $display("Ran %0d ticks under %0d register settings plus reset values.",
               ticks_accepted, settings_applied);
      $display("Faults seen: %0d stall, %0d hold drift; %0d mismatches.",
               stall_faults, drift_faults, error_count);
      if (error_count == 0 && predicted_verdicts.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
